[rtl/bpc_pkg.sv]
package bpc_pkg;

  // Field widths.
  localparam int unsigned RawW   = 24;
  localparam int unsigned CoefW  = 16;
  localparam int unsigned TempW  = 19;
  localparam int unsigned PresW  = 23;
  localparam int unsigned CfgIdxW = 3;

  // Internal widths, sized from the value ranges of the formulas.
  localparam int unsigned DtW    = RawW + 1;       // D2 - C5*256
  localparam int unsigned MulW   = DtW + CoefW + 1; // dt times a coefficient
  localparam int unsigned OffW   = 37;
  localparam int unsigned SensW  = 36;
  localparam int unsigned SensLoW = 18;
  localparam int unsigned SensHiW = SensW - SensLoW;
  localparam int unsigned PloW   = RawW + SensLoW;
  localparam int unsigned PhiW   = RawW + 1 + SensHiW;
  localparam int unsigned ProdW  = 62;
  localparam int unsigned DiffW  = 42;

  // Power-of-two scale factors of the compensation formulas.
  localparam int unsigned DtShift    = 8;
  localparam int unsigned TempShift  = 23;
  localparam int unsigned OffMulSh   = 17;
  localparam int unsigned OffDivSh   = 6;
  localparam int unsigned SensMulSh  = 16;
  localparam int unsigned SensDivSh  = 7;
  localparam int unsigned PDiv1Sh    = 21;
  localparam int unsigned PDiv2Sh    = 15;

  localparam logic signed [TempW-1:0] TempBase = TempW'(2000);

  // Pipeline depth from accepted sample to result strobe.
  localparam int unsigned Latency = 6;

  localparam int unsigned NumRegs = 6;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SENS_BASE    = 3'd0,
    REG_OFF_BASE     = 3'd1,
    REG_SENS_TEMPCO  = 3'd2,
    REG_OFF_TEMPCO   = 3'd3,
    REG_REF_TEMP_RAW = 3'd4,
    REG_TEMP_SLOPE   = 3'd5
  } cfg_reg_e;

endpackage

[rtl/barometer_pressure_compensation.sv]
// Channel   Direction  Handshake                 Payload
// sample    in         start_i, busy_o           raw_pressure_i, raw_temperature_i
// result    out        done_o (one-cycle strobe) temperature_o, pressure_o
// config    in         cfg_valid_i, cfg_ready_o  cfg_addr_i, cfg_data_i
//
// A sample pair is taken in every cycle; busy_o stays low.
// Each result is strobed on done_o in order, once its sample has passed through every stage.
// The six stages are set by the multipliers: three 25x17 products, then the
// 24x36 pressure product split into two partial products, then the final scaling.
// Reset clears the valid bits and all coefficients to zero; payload is not reset.
// The receiver cannot stall, so the pipeline never holds.
module barometer_pressure_compensation (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  output logic                                  busy_o,
  input  logic [bpc_pkg::RawW-1:0]              raw_pressure_i,
  input  logic [bpc_pkg::RawW-1:0]              raw_temperature_i,
  output logic                                  done_o,
  output logic signed [bpc_pkg::TempW-1:0]      temperature_o,
  output logic signed [bpc_pkg::PresW-1:0]      pressure_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [bpc_pkg::CfgIdxW-1:0]           cfg_addr_i,
  input  logic [bpc_pkg::CoefW-1:0]             cfg_data_i
);

  localparam int unsigned RawW    = bpc_pkg::RawW;
  localparam int unsigned CoefW   = bpc_pkg::CoefW;
  localparam int unsigned TempW   = bpc_pkg::TempW;
  localparam int unsigned PresW   = bpc_pkg::PresW;
  localparam int unsigned DtW     = bpc_pkg::DtW;
  localparam int unsigned MulW    = bpc_pkg::MulW;
  localparam int unsigned OffW    = bpc_pkg::OffW;
  localparam int unsigned SensW   = bpc_pkg::SensW;
  localparam int unsigned SensLoW = bpc_pkg::SensLoW;
  localparam int unsigned PloW    = bpc_pkg::PloW;
  localparam int unsigned PhiW    = bpc_pkg::PhiW;
  localparam int unsigned ProdW   = bpc_pkg::ProdW;
  localparam int unsigned DiffW   = bpc_pkg::DiffW;
  localparam int unsigned Latency = bpc_pkg::Latency;

  // Bias values that make an arithmetic shift truncate toward zero.
  localparam logic signed [MulW-1:0]  TempRnd = (MulW'(1) << bpc_pkg::TempShift) - MulW'(1);
  localparam logic signed [MulW-1:0]  OffRnd  = (MulW'(1) << bpc_pkg::OffDivSh) - MulW'(1);
  localparam logic signed [MulW-1:0]  SensRnd = (MulW'(1) << bpc_pkg::SensDivSh) - MulW'(1);
  localparam logic signed [ProdW-1:0] P1Rnd   = (ProdW'(1) << bpc_pkg::PDiv1Sh) - ProdW'(1);
  localparam logic signed [DiffW-1:0] P2Rnd   = (DiffW'(1) << bpc_pkg::PDiv2Sh) - DiffW'(1);

  // Coefficient registers.
  logic [CoefW-1:0] sens_base_q, off_base_q, sens_tempco_q;
  logic [CoefW-1:0] off_tempco_q, ref_temp_raw_q, temp_slope_q;

  logic in_fire;
  logic [Latency-1:0] valid_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign in_fire     = start_i & ~busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sens_base_q    <= '0;
      off_base_q     <= '0;
      sens_tempco_q  <= '0;
      off_tempco_q   <= '0;
      ref_temp_raw_q <= '0;
      temp_slope_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_addr_i)
        bpc_pkg::REG_SENS_BASE:    sens_base_q    <= cfg_data_i;
        bpc_pkg::REG_OFF_BASE:     off_base_q     <= cfg_data_i;
        bpc_pkg::REG_SENS_TEMPCO:  sens_tempco_q  <= cfg_data_i;
        bpc_pkg::REG_OFF_TEMPCO:   off_tempco_q   <= cfg_data_i;
        bpc_pkg::REG_REF_TEMP_RAW: ref_temp_raw_q <= cfg_data_i;
        bpc_pkg::REG_TEMP_SLOPE:   temp_slope_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[Latency-2:0], in_fire};
    end
  end

  // Stage 1: temperature difference.
  logic [RawW-1:0]       d1_s1_q;
  logic signed [DtW-1:0] dt_s1_q, dt_s1_d;

  assign dt_s1_d = $signed({1'b0, raw_temperature_i})
                 - $signed({1'b0, ref_temp_raw_q, {bpc_pkg::DtShift{1'b0}}});

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      d1_s1_q <= raw_pressure_i;
      dt_s1_q <= dt_s1_d;
    end
  end

  // Stage 2: the three temperature products.
  logic [RawW-1:0]        d1_s2_q;
  logic signed [MulW-1:0] mt_s2_q, mo_s2_q, ms_s2_q;
  logic signed [MulW-1:0] mt_s2_d, mo_s2_d, ms_s2_d;

  assign mt_s2_d = dt_s1_q * $signed({1'b0, temp_slope_q});
  assign mo_s2_d = dt_s1_q * $signed({1'b0, off_tempco_q});
  assign ms_s2_d = dt_s1_q * $signed({1'b0, sens_tempco_q});

  always_ff @(posedge clk_i) begin
    if (valid_q[0]) begin
      d1_s2_q <= d1_s1_q;
      mt_s2_q <= mt_s2_d;
      mo_s2_q <= mo_s2_d;
      ms_s2_q <= ms_s2_d;
    end
  end

  // Stage 3: scale the products and form TEMP, OFF and SENS.
  logic [RawW-1:0]         d1_s3_q;
  logic signed [TempW-1:0] temp_s3_q, temp_s3_d;
  logic signed [OffW-1:0]  off_s3_q, off_s3_d;
  logic signed [SensW-1:0] sens_s3_q, sens_s3_d;
  logic signed [MulW-1:0]  mt_adj, mo_adj, ms_adj;
  logic signed [MulW-1:0]  mt_div, mo_div, ms_div;

  always_comb begin
    mt_adj = mt_s2_q + (mt_s2_q[MulW-1] ? TempRnd : '0);
    mo_adj = mo_s2_q + (mo_s2_q[MulW-1] ? OffRnd : '0);
    ms_adj = ms_s2_q + (ms_s2_q[MulW-1] ? SensRnd : '0);
    mt_div = mt_adj >>> bpc_pkg::TempShift;
    mo_div = mo_adj >>> bpc_pkg::OffDivSh;
    ms_div = ms_adj >>> bpc_pkg::SensDivSh;
    temp_s3_d = bpc_pkg::TempBase + mt_div[TempW-1:0];
    off_s3_d  = $signed({{(OffW - CoefW - bpc_pkg::OffMulSh){1'b0}}, off_base_q,
                         {bpc_pkg::OffMulSh{1'b0}}}) + mo_div[OffW-1:0];
    sens_s3_d = $signed({{(SensW - CoefW - bpc_pkg::SensMulSh){1'b0}}, sens_base_q,
                         {bpc_pkg::SensMulSh{1'b0}}}) + ms_div[SensW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (valid_q[1]) begin
      d1_s3_q   <= d1_s2_q;
      temp_s3_q <= temp_s3_d;
      off_s3_q  <= off_s3_d;
      sens_s3_q <= sens_s3_d;
    end
  end

  // Stage 4: D1*SENS as two partial products on the halves of SENS.
  logic [PloW-1:0]         plo_s4_q, plo_s4_d;
  logic signed [PhiW-1:0]  phi_s4_q, phi_s4_d;
  logic signed [TempW-1:0] temp_s4_q;
  logic signed [OffW-1:0]  off_s4_q;

  assign plo_s4_d = PloW'(d1_s3_q) * PloW'(sens_s3_q[SensLoW-1:0]);
  assign phi_s4_d = $signed({1'b0, d1_s3_q}) * $signed(sens_s3_q[SensW-1:SensLoW]);

  always_ff @(posedge clk_i) begin
    if (valid_q[2]) begin
      plo_s4_q  <= plo_s4_d;
      phi_s4_q  <= phi_s4_d;
      temp_s4_q <= temp_s3_q;
      off_s4_q  <= off_s3_q;
    end
  end

  // Stage 5: merge the partial products, divide by 2^21 and subtract OFF.
  logic signed [ProdW-1:0] prod, prod_adj, prod_div;
  logic signed [DiffW-1:0] diff_s5_q, diff_s5_d;
  logic signed [TempW-1:0] temp_s5_q;

  always_comb begin
    prod = $signed({{(ProdW - SensLoW - PhiW){phi_s4_q[PhiW-1]}}, phi_s4_q,
                    {SensLoW{1'b0}}})
         + $signed({{(ProdW - PloW){1'b0}}, plo_s4_q});
    prod_adj = prod + (prod[ProdW-1] ? P1Rnd : '0);
    prod_div = prod_adj >>> bpc_pkg::PDiv1Sh;
    diff_s5_d = prod_div[DiffW-1:0]
              - $signed({{(DiffW - OffW){off_s4_q[OffW-1]}}, off_s4_q});
  end

  always_ff @(posedge clk_i) begin
    if (valid_q[3]) begin
      diff_s5_q <= diff_s5_d;
      temp_s5_q <= temp_s4_q;
    end
  end

  // Stage 6: final divide by 2^15 into the output register.
  logic signed [DiffW-1:0] diff_adj, diff_div;
  logic signed [PresW-1:0] pres_s6_q;
  logic signed [TempW-1:0] temp_s6_q;

  always_comb begin
    diff_adj = diff_s5_q + (diff_s5_q[DiffW-1] ? P2Rnd : '0);
    diff_div = diff_adj >>> bpc_pkg::PDiv2Sh;
  end

  always_ff @(posedge clk_i) begin
    if (valid_q[4]) begin
      pres_s6_q <= diff_div[PresW-1:0];
      temp_s6_q <= temp_s5_q;
    end
  end

  assign done_o        = valid_q[Latency-1];
  assign temperature_o = temp_s6_q;
  assign pressure_o    = pres_s6_q;

  // Every accepted sample comes out on done_o after the full pipeline, with no reset between.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(rst_ni, 1) && $past(rst_ni, 2) && $past(rst_ni, 3) && $past(rst_ni, 4)
      && $past(rst_ni, 5) && $past(rst_ni, 6))
    |-> (done_o == $past(in_fire, Latency)))
    else $error("result strobe does not match the accepted samples");

  // With a zero temperature slope the temperature is the base value.
  a_temp_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && temp_slope_q == '0) |-> (temperature_o == bpc_pkg::TempBase))
    else $error("temperature differs from base with zero slope");

  // A write beyond the register list leaves every coefficient alone.
  a_cfg_ignore: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o && cfg_addr_i >= bpc_pkg::CfgIdxW'(bpc_pkg::NumRegs))
    |=> ($stable(sens_base_q) && $stable(off_base_q) && $stable(sens_tempco_q)
         && $stable(off_tempco_q) && $stable(ref_temp_raw_q) && $stable(temp_slope_q)))
    else $error("out-of-range configuration write changed a coefficient");

endmodule
